[src/i2cm_pkg.sv]
// shared types and constants for the i2c master bit engine
// no dependencies; imported by every module of the block
package i2cm_pkg;

    localparam int unsigned PERIOD_W     = 16;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd250;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned BIT_IDX_W    = 3;
    localparam logic [BIT_IDX_W-1:0] LAST_BIT = 3'd7;

    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_START     = 3'd1,
        CMD_RSTART    = 3'd2,
        CMD_STOP      = 3'd3,
        CMD_WRITE     = 3'd4,
        CMD_READ_ACK  = 3'd5,
        CMD_READ_NACK = 3'd6
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START_SDA = 4'd1,
        PH_RS_REL    = 4'd2,
        PH_RS_SCL    = 4'd3,
        PH_STOP_LOW  = 4'd4,
        PH_STOP_SCL  = 4'd5,
        PH_BIT_LOW   = 4'd6,
        PH_BIT_HIGH  = 4'd7,
        PH_ACK_LOW   = 4'd8,
        PH_ACK_HIGH  = 4'd9,
        PH_TAIL      = 4'd10
    } t_phase;

    // phase timer controls, already qualified by the input transfer
    typedef struct packed {
        logic enter;
        logic finish;
        logic count;
    } t_tmr_ctl;

    typedef struct packed {
        logic              ack_seen;
        logic [BYTE_W-1:0] rx_byte;
        logic              done_res;
        logic              busy_res;
        logic              sda_out;
        logic              scl_out;
    } t_result;

endpackage

[src/i2c_master_bit_engine.sv]
// I2C master bit engine: each input transfer is one tick of the bus sequencer. A tick carries
// an optional command and the sampled SDA level and yields exactly one result transfer with
// the SCL/SDA drive levels and status. One tick is accepted every clock cycle; the only
// limit is the single result register, which frees up when the downstream side takes the
// result in the same cycle. Each bus phase lasts half_period_ticks ticks (zero acts as one).
// Write the period only while no sequence is running. Commands arriving while busy are dropped.
// depends on i2cm_pkg, i2cm_phase_timer, i2cm_seq
module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [PERIOD_W-1:0] i_cfg_wr_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,  // command[2:0], tx_byte[10:3], sda_in[11], zero
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata   // scl_out[0], sda_out[1], busy_res[2],
                                               // done_res[3], rx_byte[11:4], ack_seen[12], zero
);

    logic      w_step;
    logic      w_phase_end;
    t_tmr_ctl  w_tmr_ctl;
    t_result   w_res;
    t_result   r_out;
    logic      r_out_valid;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_step        = s_axis_tvalid && s_axis_tready;

    i2cm_phase_timer u_timer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_ctl         (w_tmr_ctl),
        .o_phase_end   (w_phase_end)
    );

    i2cm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_command   (s_axis_tdata[2:0]),
        .i_tx_byte   (s_axis_tdata[10:3]),
        .i_sda_in    (s_axis_tdata[11]),
        .i_phase_end (w_phase_end),
        .o_tmr_ctl   (w_tmr_ctl),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.ack_seen, r_out.rx_byte, r_out.done_res,
                            r_out.busy_res, r_out.sda_out, r_out.scl_out};

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("done reported together with busy");

    a_busy_no_timer_ctl_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_step |-> !(w_tmr_ctl.enter || w_tmr_ctl.finish || w_tmr_ctl.count))
        else $error("phase timer moved without an input transfer");

    a_enter_finish_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_tmr_ctl.enter, w_tmr_ctl.finish, w_tmr_ctl.count}) <= 1)
        else $error("conflicting phase timer controls");
`endif

endmodule

[src/i2cm_phase_timer.sv]
// phase timer: holds the half period register and counts ticks of the current phase
// depends on i2cm_pkg
module i2cm_phase_timer
    import i2cm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [PERIOD_W-1:0] i_cfg_wr_data,
    input  t_tmr_ctl            i_ctl,
    output logic                o_phase_end
);

    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_cnt;
    logic [PERIOD_W-1:0] n_cnt;
    logic [PERIOD_W-1:0] w_limit;

    // a period of zero behaves as one
    assign w_limit     = (r_period == '0) ? PERIOD_W'(1) : r_period;
    assign o_phase_end = (r_cnt >= w_limit);

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctl.finish) begin
            n_cnt = '0;
        end else if (i_ctl.enter) begin
            n_cnt = PERIOD_W'(1);
        end else if (i_ctl.count) begin
            n_cnt = r_cnt + PERIOD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_period <= i_cfg_wr_data;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

[src/i2cm_seq.sv]
// line sequencer: phase state machine, bit shifter, line levels and status flags
// depends on i2cm_pkg; paced by i2cm_phase_timer
module i2cm_seq
    import i2cm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [2:0]        i_command,
    input  logic [BYTE_W-1:0] i_tx_byte,
    input  logic              i_sda_in,
    input  logic              i_phase_end,
    output t_tmr_ctl          o_tmr_ctl,
    output t_result           o_res
);

    t_phase                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [BIT_IDX_W-1:0]  r_bit_idx, n_bit_idx;
    logic [BYTE_W-1:0]     r_shift, n_shift;
    logic [BYTE_W-1:0]     r_rx, n_rx;
    logic                  r_scl, n_scl;
    logic                  r_sda, n_sda;
    logic                  r_ack, n_ack;
    logic                  w_enter;
    logic                  w_finish;
    logic                  w_read;

    // next phase
    always_comb begin
        n_state  = r_state;
        w_enter  = 1'b0;
        w_finish = 1'b0;
        if (i_step) begin
            if (r_state == PH_IDLE) begin
                unique case (i_command) inside
                    CMD_START:  n_state = PH_START_SDA;
                    CMD_RSTART: n_state = PH_RS_REL;
                    CMD_STOP:   n_state = PH_STOP_LOW;
                    CMD_WRITE, CMD_READ_ACK, CMD_READ_NACK: n_state = PH_BIT_LOW;
                    default:    n_state = PH_IDLE;
                endcase
                w_enter = (n_state != PH_IDLE);
            end else if (i_phase_end) begin
                w_enter = 1'b1;
                unique case (r_state)
                    PH_RS_REL:   n_state = PH_RS_SCL;
                    PH_RS_SCL:   n_state = PH_START_SDA;
                    PH_STOP_LOW: n_state = PH_STOP_SCL;
                    PH_BIT_LOW:  n_state = PH_BIT_HIGH;
                    PH_BIT_HIGH: n_state = (r_bit_idx != LAST_BIT) ? PH_BIT_LOW : PH_ACK_LOW;
                    PH_ACK_LOW:  n_state = PH_ACK_HIGH;
                    PH_ACK_HIGH: n_state = PH_TAIL;
                    default: begin
                        n_state  = PH_IDLE;
                        w_enter  = 1'b0;
                        w_finish = 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_tmr_ctl.enter  = w_enter;
    assign o_tmr_ctl.finish = w_finish;
    assign o_tmr_ctl.count  = i_step && (r_state != PH_IDLE) && !i_phase_end;

    // a new command only counts while idle, otherwise the running one
    assign w_read = (r_state == PH_IDLE)
                  ? ((i_command == CMD_READ_ACK) || (i_command == CMD_READ_NACK))
                  : ((r_cmd == CMD_READ_ACK) || (r_cmd == CMD_READ_NACK));

    // datapath and line levels
    always_comb begin
        n_cmd     = r_cmd;
        n_bit_idx = r_bit_idx;
        n_shift   = r_shift;
        n_rx      = r_rx;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_ack     = r_ack;

        if (i_step && (r_state == PH_IDLE) && w_enter) begin
            n_cmd     = t_cmd'(i_command);
            n_bit_idx = '0;
            n_shift   = (i_command == CMD_WRITE) ? i_tx_byte : '0;
        end

        if (i_step && (r_state == PH_BIT_HIGH) && i_phase_end) begin
            n_shift   = {r_shift[BYTE_W-2:0], (w_read ? i_sda_in : 1'b0)};
            n_bit_idx = r_bit_idx + BIT_IDX_W'(1);
        end

        if (i_step && (r_state == PH_ACK_HIGH) && i_phase_end && (r_cmd == CMD_WRITE)) begin
            n_ack = !i_sda_in;
        end

        if (w_enter) begin
            case (n_state) inside
                PH_START_SDA: n_sda = 1'b0;
                PH_RS_REL: begin
                    n_scl = 1'b0;
                    n_sda = 1'b1;
                end
                PH_STOP_LOW: begin
                    n_scl = 1'b0;
                    n_sda = 1'b0;
                end
                PH_RS_SCL, PH_STOP_SCL, PH_BIT_HIGH, PH_ACK_HIGH: n_scl = 1'b1;
                PH_BIT_LOW: begin
                    n_scl = 1'b0;
                    n_sda = w_read ? 1'b1 : n_shift[BYTE_W-1];
                end
                PH_ACK_LOW: begin
                    n_scl = 1'b0;
                    n_sda = (n_cmd != CMD_READ_ACK);
                end
                default: n_scl = 1'b0;
            endcase
        end

        if (w_finish) begin
            case (r_cmd) inside
                CMD_STOP: n_sda = 1'b1;
                CMD_START, CMD_RSTART: n_scl = 1'b0;
                default: begin
                    n_scl = 1'b0;
                    n_sda = 1'b1;
                    if (w_read) begin
                        n_rx = r_shift;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= PH_IDLE;
            r_cmd     <= CMD_NONE;
            r_bit_idx <= '0;
            r_shift   <= '0;
            r_rx      <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_ack     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmd     <= n_cmd;
            r_bit_idx <= n_bit_idx;
            r_shift   <= n_shift;
            r_rx      <= n_rx;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_ack     <= n_ack;
        end
    end

    assign o_res.scl_out  = n_scl;
    assign o_res.sda_out  = n_sda;
    assign o_res.busy_res = (n_state != PH_IDLE);
    assign o_res.done_res = w_finish;
    assign o_res.rx_byte  = n_rx;
    assign o_res.ack_seen = n_ack;

`ifndef SYNTHESIS
    a_no_done_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == PH_IDLE) |-> !w_finish)
        else $error("sequence finished while idle");

    a_ack_after_last_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == PH_BIT_HIGH && n_state == PH_ACK_LOW) |-> (r_bit_idx == LAST_BIT))
        else $error("ack phase entered before eighth bit");

    a_ack_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_ack != $past(r_ack))) |->
            ($past(r_cmd) == CMD_WRITE && $past(r_state) == PH_ACK_HIGH))
        else $error("ack flag changed outside a write ack clock");
`endif

endmodule

[tb/sv/testbench.sv]
// self-checking testbench for the i2c master bit engine: every tick transfer is predicted
// by a cycle model of the bus sequencer and each result transfer is compared field by field
// depends on i2cm_pkg and i2c_master_bit_engine
module testbench
    import i2cm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 5000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [PERIOD_W-1:0] i_cfg_wr_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata = '0;   // command[2:0], tx_byte[10:3], sda_in[11], zero
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [15:0]         m_axis_tdata;        // scl_out[0], sda_out[1], busy_res[2],
                                              // done_res[3], rx_byte[11:4], ack_seen[12], zero

    // bus sequencer model state
    t_phase              bus_phase = PH_IDLE;
    t_cmd                bus_cmd = CMD_NONE;
    logic [15:0]         phase_ticks = '0;
    logic [3:0]          bit_count = '0;
    logic [7:0]          shift_byte = '0;
    logic                scl_lvl = 1'b1;
    logic                sda_lvl = 1'b1;
    logic                ack_lvl = 1'b0;
    logic [7:0]          rx_model = '0;
    logic [PERIOD_W-1:0] period_reg = PERIOD_RESET;

    t_result expected_lines[$];
    int      error_count = 0;
    int      tick_count = 0;
    int      stall_cycles = 0;
    int      src_idle_pct = 0;
    int      sink_idle_pct = 0;

    i2c_master_bit_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    function automatic logic reading();
        return bus_cmd == CMD_READ_ACK || bus_cmd == CMD_READ_NACK;
    endfunction

    function automatic void enter_phase(t_phase p);
        bus_phase = p;
        phase_ticks = 16'd1;
        case (p)
            PH_START_SDA: sda_lvl = 1'b0;
            PH_RS_REL:    begin scl_lvl = 1'b0; sda_lvl = 1'b1; end
            PH_RS_SCL:    scl_lvl = 1'b1;
            PH_STOP_LOW:  begin scl_lvl = 1'b0; sda_lvl = 1'b0; end
            PH_STOP_SCL:  scl_lvl = 1'b1;
            PH_BIT_LOW:   begin
                scl_lvl = 1'b0;
                sda_lvl = reading() ? 1'b1 : shift_byte[7];
            end
            PH_BIT_HIGH:  scl_lvl = 1'b1;
            PH_ACK_LOW:   begin
                scl_lvl = 1'b0;
                sda_lvl = (bus_cmd == CMD_READ_ACK) ? 1'b0 : 1'b1;
            end
            PH_ACK_HIGH:  scl_lvl = 1'b1;
            default:      scl_lvl = 1'b0;
        endcase
    endfunction

    // closes the running phase, returns 1 when the whole sequence is over
    function automatic logic close_phase(logic sda_smp);
        case (bus_phase)
            PH_RS_REL:   enter_phase(PH_RS_SCL);
            PH_RS_SCL:   enter_phase(PH_START_SDA);
            PH_STOP_LOW: enter_phase(PH_STOP_SCL);
            PH_BIT_LOW:  enter_phase(PH_BIT_HIGH);
            PH_BIT_HIGH: begin
                shift_byte = {shift_byte[6:0], reading() ? sda_smp : 1'b0};
                bit_count = bit_count + 4'd1;
                enter_phase(bit_count < 4'd8 ? PH_BIT_LOW : PH_ACK_LOW);
            end
            PH_ACK_LOW:  enter_phase(PH_ACK_HIGH);
            PH_ACK_HIGH: begin
                if (bus_cmd == CMD_WRITE)
                    ack_lvl = (sda_smp == 1'b0);
                enter_phase(PH_TAIL);
            end
            default: begin
                if (bus_cmd == CMD_STOP) begin
                    sda_lvl = 1'b1;
                end else if (bus_cmd == CMD_START || bus_cmd == CMD_RSTART) begin
                    scl_lvl = 1'b0;
                end else begin
                    scl_lvl = 1'b0;
                    sda_lvl = 1'b1;
                    if (reading())
                        rx_model = shift_byte;
                end
                bus_phase = PH_IDLE;
                phase_ticks = '0;
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic t_result step_bus_model(logic [2:0] code, logic [7:0] txb,
                                               logic sda_smp);
        logic [15:0] limit;
        t_result     r;
        limit = (period_reg == '0) ? 16'd1 : period_reg;
        r = '0;
        if (bus_phase == PH_IDLE) begin
            if (code >= CMD_START && code <= CMD_READ_NACK) begin
                bus_cmd = t_cmd'(code);
                bit_count = '0;
                case (t_cmd'(code))
                    CMD_START:  enter_phase(PH_START_SDA);
                    CMD_RSTART: enter_phase(PH_RS_REL);
                    CMD_STOP:   enter_phase(PH_STOP_LOW);
                    default: begin
                        shift_byte = (code == CMD_WRITE) ? txb : 8'd0;
                        enter_phase(PH_BIT_LOW);
                    end
                endcase
            end
        end else if (phase_ticks >= limit) begin
            r.done_res = close_phase(sda_smp);
        end else begin
            phase_ticks = phase_ticks + 16'd1;
        end
        r.scl_out  = scl_lvl;
        r.sda_out  = sda_lvl;
        r.busy_res = (bus_phase != PH_IDLE);
        r.rx_byte  = rx_model;
        r.ack_seen = ack_lvl;
        return r;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[12:0]);
            if (expected_lines.size() == 0) begin
                $error("result transfer %h with nothing expected", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_lines.pop_front();
                if (got.scl_out !== want.scl_out) begin
                    $error("scl_out expected %0d actual %0d", want.scl_out, got.scl_out);
                    error_count++;
                end
                if (got.sda_out !== want.sda_out) begin
                    $error("sda_out expected %0d actual %0d", want.sda_out, got.sda_out);
                    error_count++;
                end
                if (got.busy_res !== want.busy_res) begin
                    $error("busy_res expected %0d actual %0d", want.busy_res, got.busy_res);
                    error_count++;
                end
                if (got.done_res !== want.done_res) begin
                    $error("done_res expected %0d actual %0d", want.done_res, got.done_res);
                    error_count++;
                end
                if (got.rx_byte !== want.rx_byte) begin
                    $error("rx_byte expected %h actual %h", want.rx_byte, got.rx_byte);
                    error_count++;
                end
                if (got.ack_seen !== want.ack_seen) begin
                    $error("ack_seen expected %0d actual %0d", want.ack_seen, got.ack_seen);
                    error_count++;
                end
                if (m_axis_tdata[15:13] !== 3'd0) begin
                    $error("tdata padding expected 0 actual %0d", m_axis_tdata[15:13]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_tick(input logic [2:0] code, input logic [7:0] txb,
                             input logic sda_smp);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, sda_smp, txb, code};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_lines.push_back(step_bus_model(code, txb, sda_smp));
        tick_count++;
    endtask

    task automatic pause_ticks();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_lines.size() != 0)
            @(posedge i_clk);
    endtask

    // only called with the sequencer idle
    task automatic set_period(input logic [PERIOD_W-1:0] ticks);
        pause_ticks();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= ticks;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        period_reg = ticks;
    endtask

    // issues one command and keeps ticking until the sequence is over;
    // busy ticks carry stray commands at the given rate
    task automatic run_command(input logic [2:0] code, input logic [7:0] txb,
                               input logic [7:0] line_byte, input logic line_ack,
                               input int noise_pct);
        logic [2:0] stray;
        logic       sda_smp;
        send_tick(code, txb, 1'($urandom));
        while (bus_phase != PH_IDLE) begin
            stray = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(1, 7)) : CMD_NONE;
            case (bus_phase)
                PH_BIT_HIGH: sda_smp = line_byte[LAST_BIT - bit_count[2:0]];
                PH_ACK_HIGH: sda_smp = line_ack;
                default:     sda_smp = 1'($urandom);
            endcase
            send_tick(stray, 8'($urandom), sda_smp);
        end
    endtask

    task automatic test_reset_period();
        run_command(CMD_NONE, 8'hFF, 8'h00, 1'b0, 0);
        run_command(CMD_UNUSED, 8'h00, 8'h00, 1'b0, 0);
        run_command(CMD_START, 8'h00, 8'h00, 1'b0, 30);
    endtask

    task automatic test_each_command();
        set_period(16'd1);
        run_command(CMD_START, 8'h00, 8'h00, 1'b0, 0);
        run_command(CMD_WRITE, 8'h00, 8'h00, 1'b0, 0);
        run_command(CMD_WRITE, 8'hFF, 8'h00, 1'b1, 0);
        run_command(CMD_WRITE, 8'hA5, 8'h00, 1'b0, 100);
        run_command(CMD_RSTART, 8'h00, 8'h00, 1'b0, 0);
        run_command(CMD_READ_ACK, 8'h00, 8'h00, 1'b0, 0);
        run_command(CMD_READ_NACK, 8'h00, 8'hFF, 1'b1, 0);
        run_command(CMD_READ_ACK, 8'h00, 8'h5A, 1'b0, 100);
        run_command(CMD_STOP, 8'h00, 8'h00, 1'b0, 100);
        // zero period behaves like one
        set_period(16'd0);
        run_command(CMD_START, 8'h00, 8'h00, 1'b0, 0);
        run_command(CMD_WRITE, 8'h3C, 8'h00, 1'b0, 50);
        run_command(CMD_READ_NACK, 8'h00, 8'hC3, 1'b1, 50);
        run_command(CMD_RSTART, 8'h00, 8'h00, 1'b0, 100);
        run_command(CMD_STOP, 8'h00, 8'h00, 1'b0, 0);
        set_period(16'd2);
        run_command(CMD_WRITE, 8'h81, 8'h00, 1'b1, 100);
        run_command(CMD_READ_ACK, 8'h00, 8'h7E, 1'b0, 0);
    endtask

    task automatic test_long_period();
        set_period(16'd300);
        run_command(CMD_START, 8'h00, 8'h00, 1'b0, 0);
        set_period(16'd3);
        run_command(CMD_STOP, 8'h00, 8'h00, 1'b0, 20);
    endtask

    // mostly complete command sequences, with idle-time noise and stray busy commands
    task automatic test_random(input int n_ticks);
        int target;
        int noise;
        target = tick_count + n_ticks;
        while (tick_count < target) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 4))
                    0:       set_period(16'd0);
                    1:       set_period(16'd1);
                    2:       set_period(16'd2);
                    default: set_period(16'($urandom_range(1, 5)));
                endcase
            end
            case ($urandom_range(0, 3))
                0:       noise = 0;
                1:       noise = 10;
                2:       noise = 50;
                default: noise = 100;
            endcase
            if ($urandom_range(0, 9) == 0)
                run_command($urandom_range(0, 1) ? CMD_NONE : CMD_UNUSED, 8'($urandom),
                            8'($urandom), 1'($urandom), noise);
            else
                run_command(3'($urandom_range(CMD_START, CMD_READ_NACK)), 8'($urandom),
                            8'($urandom), 1'($urandom), noise);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct  = 19;
        sink_idle_pct = 74;
        test_reset_period();
        test_each_command();

        src_idle_pct  = 74;
        sink_idle_pct = 19;
        test_random(120);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_long_period();
        test_random(120);

        pause_ticks();
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
